FILE: hdl/x86_shift_rotate_adc_flag_alu_unit_defines.svh
// Assertion macros for the shift/rotate/adc flag ALU.
// Depends on nothing; included by the top module, which carries the assertions.
`ifndef X86_SHIFT_ROTATE_ADC_FLAG_ALU_UNIT_DEFINES_SVH
`define X86_SHIFT_ROTATE_ADC_FLAG_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRFALU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srfalu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SRFALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srfalu: next-cycle check failed");

`endif

FILE: hdl/srfalu_pkg.sv
// Shared types, codes and width helpers for the shift/rotate/adc flag ALU.
// Depends on nothing.
`timescale 1ns / 1ps

package srfalu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    OP_SHL = 4'd0,
    OP_SHR = 4'd1,
    OP_SAR = 4'd2,
    OP_ROL = 4'd3,
    OP_ROR = 4'd4,
    OP_RCL = 4'd5,
    OP_RCR = 4'd6,
    OP_ADC = 4'd7,
    OP_JMP = 4'd8,
    OP_SET = 4'd9,
    OP_NOP = 4'd10
  } op_e;

  localparam logic [3:0] COND_A      = 4'd0;
  localparam logic [3:0] COND_AE     = 4'd1;
  localparam logic [3:0] COND_B      = 4'd2;
  localparam logic [3:0] COND_BE     = 4'd3;
  localparam logic [3:0] COND_E      = 4'd4;
  localparam logic [3:0] COND_NE     = 4'd5;
  localparam logic [3:0] COND_G      = 4'd6;
  localparam logic [3:0] COND_GE     = 4'd7;
  localparam logic [3:0] COND_L      = 4'd8;
  localparam logic [3:0] COND_LE     = 4'd9;
  localparam logic [3:0] COND_O      = 4'd10;
  localparam logic [3:0] COND_ALWAYS = 4'd11;

  localparam logic [1:0] W8  = 2'd0;
  localparam logic [1:0] W16 = 2'd1;
  localparam logic [1:0] W32 = 2'd2;
  localparam logic [1:0] W64 = 2'd3;

  // Decoded request as it travels from front to back.
  typedef struct packed {
    op_e         op;
    logic [3:0]  cond;
    logic [1:0]  wsel;
    logic [63:0] opa;      // masked operand, or raw target for a jump
    logic [63:0] opb;      // masked second addend
    logic [5:0]  cnt;      // masked shift count
    logic [5:0]  rot_amt;  // left-rotate amount for rol/ror
    logic [6:0]  rc_amt;   // left-rotate amount over w+1 bits for rcl/rcr
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       pop;
    logic [3:0] flags;  // cf, of, sf, zf
  } bk_stat_t;

  function automatic logic [63:0] width_mask(input logic [1:0] ws);
    logic [63:0] m;
    case (ws)
      W8:      m = 64'h0000_0000_0000_00ff;
      W16:     m = 64'h0000_0000_0000_ffff;
      W32:     m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] width_val(input logic [1:0] ws);
    logic [6:0] v;
    case (ws)
      W8:      v = 7'd8;
      W16:     v = 7'd16;
      W32:     v = 7'd32;
      default: v = 7'd64;
    endcase
    return v;
  endfunction

  function automatic logic msb_at(input logic [63:0] x, input logic [1:0] ws);
    logic b;
    case (ws)
      W8:      b = x[7];
      W16:     b = x[15];
      W32:     b = x[31];
      default: b = x[63];
    endcase
    return b;
  endfunction

  function automatic logic msb1_at(input logic [63:0] x, input logic [1:0] ws);
    logic b;
    case (ws)
      W8:      b = x[6];
      W16:     b = x[14];
      W32:     b = x[30];
      default: b = x[62];
    endcase
    return b;
  endfunction

  // Bit just above the operand width.
  function automatic logic bit_at_w(input logic [64:0] x, input logic [1:0] ws);
    logic b;
    case (ws)
      W8:      b = x[8];
      W16:     b = x[16];
      W32:     b = x[32];
      default: b = x[64];
    endcase
    return b;
  endfunction

  function automatic logic [63:0] sext_w(input logic [63:0] x, input logic [1:0] ws);
    logic [63:0] y;
    case (ws)
      W8:      y = {{56{x[7]}}, x[7:0]};
      W16:     y = {{48{x[15]}}, x[15:0]};
      W32:     y = {{32{x[31]}}, x[31:0]};
      default: y = x;
    endcase
    return y;
  endfunction

  // Fold a left-shifted operand back into its width to form a rotate.
  function automatic logic [63:0] rot_fold(input logic [127:0] x, input logic [1:0] ws);
    logic [63:0] y;
    case (ws)
      W8:      y = {56'd0, x[7:0] | x[15:8]};
      W16:     y = {48'd0, x[15:0] | x[31:16]};
      W32:     y = {32'd0, x[31:0] | x[63:32]};
      default: y = x[63:0] | x[127:64];
    endcase
    return y;
  endfunction

  // Place the carry just above the operand width.
  function automatic logic [64:0] rc_put_top(input logic [63:0] a, input logic cf,
                                             input logic [1:0] ws);
    logic [64:0] y;
    y = {1'b0, a};
    case (ws)
      W8:      y[8]  = cf;
      W16:     y[16] = cf;
      W32:     y[32] = cf;
      default: y[64] = cf;
    endcase
    return y;
  endfunction

  // Fold a left-shifted (w+1)-bit word back into w+1 bits.
  function automatic logic [64:0] rc_fold(input logic [129:0] x, input logic [1:0] ws);
    logic [64:0] y;
    case (ws)
      W8:      y = {56'd0, x[8:0] | x[17:9]};
      W16:     y = {48'd0, x[16:0] | x[33:17]};
      W32:     y = {32'd0, x[32:0] | x[65:33]};
      default: y = x[64:0] | x[129:65];
    endcase
    return y;
  endfunction

endpackage

FILE: hdl/srfalu_if.sv
// Request and response channel interfaces of the shift/rotate/adc flag ALU.
// Depends on nothing.
`timescale 1ns / 1ps

interface srfalu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [3:0]  cond;
  logic [1:0]  width_sel;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, op, cond, width_sel, operand_a, operand_b, input ready);
  modport sink   (input valid, op, cond, width_sel, operand_a, operand_b, output ready);
endinterface

interface srfalu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        branch_taken;
  logic        carry_out;
  logic        overflow_out;
  logic        sign_out;
  logic        zero_out;

  modport source (output valid, result, branch_taken, carry_out, overflow_out, sign_out,
                  zero_out, input ready);
  modport sink   (input valid, result, branch_taken, carry_out, overflow_out, sign_out,
                  zero_out, output ready);
endinterface

FILE: hdl/x86_shift_rotate_adc_flag_alu_unit.sv
// x86-style shift, rotate, add-with-carry and condition ALU with CF/OF/SF/ZF.
// Depends on srfalu_pkg, srfalu_if, srfalu_front, srfalu_queue, srfalu_back
// and the assertion macros header.
`timescale 1ns / 1ps
`include "x86_shift_rotate_adc_flag_alu_unit_defines.svh"

// Usage:
//   req_i carries one request per valid/ready handshake: op, cond, width_sel,
//   operand_a and operand_b. rsp_o returns exactly one response per request,
//   in order: result, branch_taken and the four flags after the operation.
//   An accepted request is written into the queue, then executed into the
//   response register that drives rsp_o; a stall can hold it in the queue.
//   Throughput: one request per cycle, sustained while rsp_o.ready stays high. The
//   execute stage finishes any shift, rotate or add combinationally, and the flag
//   register it writes feeds the very next request, so no request waits on another.
//   Stalls: when rsp_o.ready is low the response register holds; the back
//   end stops popping and the queue (QUEUE_DEPTH entries) keeps absorbing
//   requests until it is full, then req_i.ready drops.
//   Reset: rst_ni clears the flags to zero, empties the queue and drops
//   rsp_o.valid. There is no clearing pass; requests are taken right away.
//   Flags change only with a request that is executed; jumps, sets and
//   unknown operations leave them as they are.
module x86_shift_rotate_adc_flag_alu_unit import srfalu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srfalu_in_if.sink     req_i,
  srfalu_out_if.source  rsp_o
);

  item_t    fe_item;
  item_t    q_item;
  logic     push;
  logic     pop;
  q_stat_t  q_st;
  bk_stat_t bk_st;

  // Decode and mask the request; push it while the queue has room.
  srfalu_front u_front (
    .req_i  (req_i),
    .q_st_i (q_st),
    .item_o (fe_item),
    .push_o (push)
  );

  // Decouple acceptance from execution.
  srfalu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fe_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_st)
  );

  // Execute against the live flags and hold the response for the sink.
  srfalu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item),
    .empty_i (q_st.empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o),
    .stat_o  (bk_st)
  );

  // An empty queue with nothing arriving leaves nothing to execute next cycle.
  `SRFALU_ASSERT_NEXT(a_no_pop_from_empty, clk_i, rst_ni, q_st.empty && !push, !bk_st.pop)

  // A request landing in an empty queue with a free output executes next cycle.
  `SRFALU_ASSERT_NEXT(a_fast_path, clk_i, rst_ni,
                      push && q_st.empty && (!rsp_o.valid || rsp_o.ready), bk_st.pop)

  // Flags move only when a request executes.
  `SRFALU_ASSERT_NEXT(a_flags_hold, clk_i, rst_ni, !bk_st.pop, $stable(bk_st.flags))

endmodule

FILE: hdl/srfalu_front.sv
// Front end: accepts requests, masks operands and precomputes rotate amounts.
// Depends on srfalu_pkg and srfalu_in_if.
`timescale 1ns / 1ps

module srfalu_front import srfalu_pkg::*; (
  srfalu_in_if.sink req_i,
  input  q_stat_t   q_st_i,
  output item_t     item_o,
  output logic      push_o
);

  function automatic logic [4:0] mod9(input logic [4:0] c);
    logic [4:0] r;
    if (c >= 5'd27) begin
      r = c - 5'd27;
    end else if (c >= 5'd18) begin
      r = c - 5'd18;
    end else if (c >= 5'd9) begin
      r = c - 5'd9;
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [1:0]  ws;
  logic [63:0] m;
  logic [6:0]  wv;
  logic [5:0]  cnt;
  logic [5:0]  r_rot;
  logic [6:0]  r_rc;
  op_e         opd;

  assign req_i.ready = !q_st_i.full;
  assign push_o      = req_i.valid && !q_st_i.full;

  always_comb begin
    ws  = req_i.width_sel;
    m   = width_mask(ws);
    wv  = width_val(ws);
    opd = (req_i.op <= OP_SET) ? op_e'(req_i.op) : OP_NOP;
    cnt = (ws == W64) ? req_i.operand_b[5:0] : {1'b0, req_i.operand_b[4:0]};

    r_rot = cnt & 6'(wv - 7'd1);

    case (ws)
      W8:      r_rc = {2'b00, mod9(cnt[4:0])};
      W16:     r_rc = (cnt >= 6'd17) ? {1'b0, cnt - 6'd17} : {1'b0, cnt};
      default: r_rc = {1'b0, cnt};
    endcase

    item_o.op   = opd;
    item_o.cond = req_i.cond;
    item_o.wsel = ws;
    item_o.opa  = (opd == OP_JMP) ? req_i.operand_a : (req_i.operand_a & m);
    item_o.opb  = req_i.operand_b & m;
    item_o.cnt  = cnt;
    // Right rotates become left rotates by the complement.
    item_o.rot_amt = (opd == OP_ROR && r_rot != 6'd0) ? 6'(wv - {1'b0, r_rot}) : r_rot;
    item_o.rc_amt  = (opd == OP_RCR && r_rc != 7'd0) ? (wv + 7'd1 - r_rc) : r_rc;
  end

endmodule

FILE: hdl/srfalu_queue.sv
// Small FIFO of decoded requests between front and back.
// Depends on srfalu_pkg.
`timescale 1ns / 1ps

module srfalu_queue import srfalu_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: hdl/srfalu_back.sv
// Back end: runs one request per cycle while rsp_o is free, keeps the flags, holds the result.
// Depends on srfalu_pkg and srfalu_out_if.
`timescale 1ns / 1ps

module srfalu_back import srfalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       empty_i,
  output logic       pop_o,
  srfalu_out_if.source rsp_o,
  output bk_stat_t   stat_o
);

  logic        vld_q, vld_d;
  logic [63:0] res_q, res_d;
  logic        taken_q, taken_d;
  logic        cf_q, cf_d, of_q, of_d, sf_q, sf_d, zf_q, zf_d;

  logic [1:0]   ws;
  logic [63:0]  m;
  logic         sgn;
  logic         c_nz, c_one;
  logic         holds;
  logic [64:0]  shl_x, shr_x, sar_x;
  logic [127:0] rot_x;
  logic [63:0]  rot_r;
  logic [129:0] rc_x;
  logic [64:0]  rc_z;
  logic [64:0]  sum;

  function automatic logic cond_holds(input logic [3:0] c, input logic cf, input logic of,
                                      input logic sf, input logic zf);
    logic h;
    case (c)
      COND_A:      h = !cf && !zf;
      COND_AE:     h = !cf;
      COND_B:      h = cf;
      COND_BE:     h = cf || zf;
      COND_E:      h = zf;
      COND_NE:     h = !zf;
      COND_G:      h = !zf && (sf == of);
      COND_GE:     h = (sf == of);
      COND_L:      h = (sf != of);
      COND_LE:     h = zf || (sf != of);
      COND_O:      h = of;
      COND_ALWAYS: h = 1'b1;
      default:     h = 1'b0;
    endcase
    return h;
  endfunction

  assign pop_o = !empty_i && (!vld_q || rsp_o.ready);

  always_comb begin
    ws    = item_i.wsel;
    m     = width_mask(ws);
    sgn   = msb_at(item_i.opa, ws);
    c_nz  = (item_i.cnt != 6'd0);
    c_one = (item_i.cnt == 6'd1);
    holds = cond_holds(item_i.cond, cf_q, of_q, sf_q, zf_q);

    shl_x = {1'b0, item_i.opa} << item_i.cnt;
    shr_x = {item_i.opa, 1'b0} >> item_i.cnt;
    sar_x = $signed({sext_w(item_i.opa, ws), 1'b0}) >>> item_i.cnt;
    rot_x = {64'd0, item_i.opa} << item_i.rot_amt;
    rot_r = rot_fold(rot_x, ws);
    rc_x  = {65'd0, rc_put_top(item_i.opa, cf_q, ws)} << item_i.rc_amt;
    rc_z  = rc_fold(rc_x, ws);
    sum   = {1'b0, item_i.opa} + {1'b0, item_i.opb} + {64'd0, cf_q};

    res_d   = 64'd0;
    taken_d = 1'b0;
    cf_d    = cf_q;
    of_d    = of_q;
    sf_d    = sf_q;
    zf_d    = zf_q;

    case (item_i.op)
      OP_SHL: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = shl_x[63:0] & m;
          cf_d  = bit_at_w(shl_x, ws);
          if (c_one) of_d = msb_at(res_d, ws) ^ cf_d;
        end
      end
      OP_SHR: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = shr_x[64:1];
          cf_d  = shr_x[0];
          if (c_one) of_d = sgn;
        end
      end
      OP_SAR: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = sar_x[64:1] & m;
          cf_d  = sar_x[0];
          if (c_one) of_d = 1'b0;
        end
      end
      OP_ROL: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = rot_r;
          cf_d  = rot_r[0];
          if (c_one) of_d = msb_at(rot_r, ws) ^ rot_r[0];
        end
      end
      OP_ROR: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = rot_r;
          cf_d  = msb_at(rot_r, ws);
          if (c_one) of_d = msb_at(rot_r, ws) ^ msb1_at(rot_r, ws);
        end
      end
      OP_RCL: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = rc_z[63:0] & m;
          cf_d  = bit_at_w(rc_z, ws);
          of_d  = cf_d ^ msb_at(res_d, ws);
        end
      end
      OP_RCR: begin
        res_d = item_i.opa;
        if (c_nz) begin
          res_d = rc_z[63:0] & m;
          cf_d  = bit_at_w(rc_z, ws);
          of_d  = msb_at(res_d, ws) ^ msb1_at(res_d, ws);
        end
      end
      OP_ADC: begin
        res_d = sum[63:0] & m;
        cf_d  = bit_at_w(sum, ws);
        of_d  = msb_at((item_i.opa ^ res_d) & (item_i.opb ^ res_d), ws);
        sf_d  = msb_at(res_d, ws);
        zf_d  = (res_d == 64'd0);
      end
      OP_JMP: begin
        if (holds) begin
          taken_d = 1'b1;
          res_d   = item_i.opa;
        end
      end
      OP_SET: begin
        res_d = {63'd0, holds};
      end
      default: begin
        res_d = 64'd0;
      end
    endcase

    vld_d = pop_o || (vld_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cf_q  <= 1'b0;
      of_q  <= 1'b0;
      sf_q  <= 1'b0;
      zf_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (pop_o) begin
        cf_q <= cf_d;
        of_q <= of_d;
        sf_q <= sf_d;
        zf_q <= zf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q   <= res_d;
      taken_q <= taken_d;
    end
  end

  // Flags register only moves with a new result, so it doubles as the flag outputs.
  assign rsp_o.valid        = vld_q;
  assign rsp_o.result       = res_q;
  assign rsp_o.branch_taken = taken_q;
  assign rsp_o.carry_out    = cf_q;
  assign rsp_o.overflow_out = of_q;
  assign rsp_o.sign_out     = sf_q;
  assign rsp_o.zero_out     = zf_q;

  assign stat_o.pop   = pop_o;
  assign stat_o.flags = {cf_q, of_q, sf_q, zf_q};

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the x86-style shift/rotate/adc flag ALU unit.
// Depends on srfalu_pkg, srfalu_if and x86_shift_rotate_adc_flag_alu_unit.
`timescale 1ns / 1ps

module testbench;
  import srfalu_pkg::*;

  // Codes the package leaves unnamed: the top unknown operation and the unknown conditions.
  localparam logic [3:0] OP_UNUSED_TOP   = 4'd15;
  localparam logic [3:0] COND_UNUSED_LOW = 4'd12;
  localparam logic [3:0] COND_UNUSED_TOP = 4'd15;

  localparam int IDLE_LIMIT     = 2000;  // cycles with no request or response moving
  localparam int DRAIN_CYCLES   = 8;     // quiet tail after the last response, with margin
  localparam int RANDOM_ITEMS   = 1650;
  localparam int LONG_HOLD      = 250;   // receiver hold-off that fills the queue
  localparam int HOLD_SPACING   = 700;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  cond;
    logic [1:0]  wsel;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] result;
    logic        taken;
    logic        cf;
    logic        of;
    logic        sf;
    logic        zf;
  } alu_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srfalu_in_if  req_if ();
  srfalu_out_if rsp_if ();

  x86_shift_rotate_adc_flag_alu_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  alu_req_t pending_req_q[$];
  alu_rsp_t expected_rsp_q[$];
  alu_req_t drv_item;
  int       req_accept_cnt = 0;
  int       mismatch_cnt = 0;
  int       idle_cycles = 0;
  int       burst_left, gap_left;
  int       seg_left, stall_mode, hold_left, next_hold_at;

  // Architectural flags as the predictor sees them; they start cleared, as out of reset.
  logic flag_cf = 1'b0, flag_of = 1'b0, flag_sf = 1'b0, flag_zf = 1'b0;

  // ---------------------------------------------------------------------------
  // Flag predictor
  // ---------------------------------------------------------------------------

  function automatic logic cond_met(input logic [3:0] cc);
    logic hit;
    case (cc)
      COND_A:      hit = !flag_cf && !flag_zf;
      COND_AE:     hit = !flag_cf;
      COND_B:      hit = flag_cf;
      COND_BE:     hit = flag_cf || flag_zf;
      COND_E:      hit = flag_zf;
      COND_NE:     hit = !flag_zf;
      COND_G:      hit = !flag_zf && (flag_sf == flag_of);
      COND_GE:     hit = flag_sf == flag_of;
      COND_L:      hit = flag_sf != flag_of;
      COND_LE:     hit = flag_zf || (flag_sf != flag_of);
      COND_O:      hit = flag_of;
      COND_ALWAYS: hit = 1'b1;
      default:     hit = 1'b0;  // unknown conditions never hold
    endcase
    return hit;
  endfunction

  // Execute one request against the flag copy and return its response.
  function automatic alu_rsp_t alu_predict(input alu_req_t rq);
    alu_rsp_t    rsp;
    int          wd, hi, cnt, rot, k;
    logic [63:0] m, a, b, res, v;
    logic [64:0] sum;
    logic        sgn, cfv, ncf;
    wd  = 8 << rq.wsel;
    hi  = wd - 1;
    m   = (wd == 64) ? '1 : ((64'd1 << wd) - 64'd1);
    a   = rq.a & m;
    b   = rq.b & m;
    cnt = int'(rq.b[5:0]) & ((wd == 64) ? 63 : 31);
    sgn = a[hi];
    res = 64'd0;
    rsp.taken = 1'b0;
    case (rq.op)
      OP_SHL: begin
        res = a;
        if (cnt != 0) begin
          res = (cnt >= wd) ? 64'd0 : ((a << cnt) & m);
          if (cnt <= wd) flag_cf = a[wd - cnt];
          else flag_cf = 1'b0;
          if (cnt == 1) flag_of = res[hi] ^ flag_cf;
        end
      end
      OP_SHR: begin
        res = a;
        if (cnt != 0) begin
          res = (cnt >= wd) ? 64'd0 : (a >> cnt);
          if (cnt <= wd) flag_cf = a[cnt - 1];
          else flag_cf = 1'b0;
          if (cnt == 1) flag_of = sgn;
        end
      end
      OP_SAR: begin
        res = a;
        if (cnt != 0) begin
          if (cnt >= wd) res = sgn ? m : 64'd0;
          else res = (a >> cnt) | (sgn ? (m & ~(m >> cnt)) : 64'd0);
          if (cnt <= wd) flag_cf = a[cnt - 1];
          else flag_cf = sgn;
          if (cnt == 1) flag_of = 1'b0;
        end
      end
      OP_ROL: begin
        res = a;
        if (cnt != 0) begin
          rot = cnt & hi;
          if (rot != 0) res = ((a << rot) | (a >> (wd - rot))) & m;
          flag_cf = res[0];
          if (cnt == 1) flag_of = res[hi] ^ flag_cf;
        end
      end
      OP_ROR: begin
        res = a;
        if (cnt != 0) begin
          rot = cnt & hi;
          if (rot != 0) res = ((a >> rot) | (a << (wd - rot))) & m;
          flag_cf = res[hi];
          if (cnt == 1) flag_of = flag_cf ^ res[hi - 1];
        end
      end
      OP_RCL, OP_RCR: begin
        res = a;
        if (cnt != 0) begin
          // Narrow widths rotate over w+1 bits, so the count wraps at w+1.
          rot = (wd <= 16) ? (cnt % (wd + 1)) : cnt;
          v   = a;
          cfv = flag_cf;
          for (k = 0; k < rot; k++) begin
            if (rq.op == OP_RCL) begin
              ncf = v[hi];
              v   = ((v << 1) | {63'd0, cfv}) & m;
            end else begin
              ncf   = v[0];
              v     = v >> 1;
              v[hi] = cfv;
            end
            cfv = ncf;
          end
          res     = v;
          flag_cf = cfv;
          if (rq.op == OP_RCL) flag_of = cfv ^ v[hi];
          else flag_of = v[hi] ^ v[hi - 1];
        end
      end
      OP_ADC: begin
        sum     = {1'b0, a} + {1'b0, b} + {64'd0, flag_cf};
        res     = sum[63:0] & m;
        flag_cf = sum[wd];
        v       = (a ^ res) & (b ^ res);
        flag_of = v[hi];
        flag_sf = res[hi];
        flag_zf = (res == 64'd0);
      end
      OP_JMP: begin
        if (cond_met(rq.cond)) begin
          rsp.taken = 1'b1;
          res       = rq.a;  // target is passed through unmasked
        end
      end
      OP_SET: res = {63'd0, cond_met(rq.cond)};
      default: ;  // unknown operations touch nothing
    endcase
    rsp.result = res;
    rsp.cf     = flag_cf;
    rsp.of     = flag_of;
    rsp.sf     = flag_sf;
    rsp.zf     = flag_zf;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %h expected %h", $time, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_rsp(input alu_rsp_t got, input alu_rsp_t want);
    if (got.result !== want.result) report_mismatch("result", got.result, want.result);
    if (got.taken !== want.taken)
      report_mismatch("branch_taken", {63'd0, got.taken}, {63'd0, want.taken});
    if (got.cf !== want.cf) report_mismatch("carry_out", {63'd0, got.cf}, {63'd0, want.cf});
    if (got.of !== want.of)
      report_mismatch("overflow_out", {63'd0, got.of}, {63'd0, want.of});
    if (got.sf !== want.sf) report_mismatch("sign_out", {63'd0, got.sf}, {63'd0, want.sf});
    if (got.zf !== want.zf) report_mismatch("zero_out", {63'd0, got.zf}, {63'd0, want.zf});
  endtask

  // Predict on every accepted request, compare on every accepted response.
  always @(posedge clk_i) begin
    alu_req_t rq;
    alu_rsp_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        rq.op   = req_if.op;
        rq.cond = req_if.cond;
        rq.wsel = req_if.width_sel;
        rq.a    = req_if.operand_a;
        rq.b    = req_if.operand_b;
        expected_rsp_q.push_back(alu_predict(rq));
        req_accept_cnt <= req_accept_cnt + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.result = rsp_if.result;
        got.taken  = rsp_if.branch_taken;
        got.cf     = rsp_if.carry_out;
        got.of     = rsp_if.overflow_out;
        got.sf     = rsp_if.sign_out;
        got.zf     = rsp_if.zero_out;
        if (expected_rsp_q.size() == 0) report_mismatch("unexpected response", got.result, '0);
        else check_rsp(got, expected_rsp_q.pop_front());
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no request or response moved for %0d cycles",
                 $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.op        <= '0;
      req_if.cond      <= '0;
      req_if.width_sel <= '0;
      req_if.operand_a <= '0;
      req_if.operand_b <= '0;
      burst_left       <= 1;
      gap_left         <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      // Advance only once the offered request has been taken.
      if (gap_left != 0 || pending_req_q.size() == 0) begin
        req_if.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        drv_item = pending_req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.op        <= drv_item.op;
        req_if.cond      <= drv_item.cond;
        req_if.width_sel <= drv_item.wsel;
        req_if.operand_a <= drv_item.a;
        req_if.operand_b <= drv_item.b;
        if (burst_left <= 1) begin
          // Mostly short bursts; now and then a long one with no idling at all.
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
          gap_left   <= $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response sink: segments of steady, light and heavy stalling, plus
  // periodic long hold-offs so the queue fills and req ready drops
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      seg_left     <= 0;
      stall_mode   <= 0;
      hold_left    <= 0;
      next_hold_at <= 300;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (req_accept_cnt >= next_hold_at) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end else begin
      if (seg_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        seg_left   <= $urandom_range(10, 120);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_req(input logic [3:0] op, input logic [3:0] cc, input logic [1:0] ws,
                          input logic [63:0] a, input logic [63:0] b);
    alu_req_t rq;
    rq.op   = op;
    rq.cond = cc;
    rq.wsel = ws;
    rq.a    = a;
    rq.b    = b;
    pending_req_q.push_back(rq);
  endtask

  // Bias operands toward zero, all ones, sign boundaries and single bits.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0:       v = 64'd0;
      1:       v = '1;
      2:       v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
      3:       v = 64'h7fff_ffff_ffff_ffff >> (8 * $urandom_range(0, 7));
      4:       v = 64'd1 << $urandom_range(0, 63);
      5:       v = (64'd1 << $urandom_range(0, 63)) - 64'd1;
      6:       v = 64'($urandom_range(0, 3));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic add_random_req();
    logic [3:0]  op, cc;
    logic [1:0]  ws;
    logic [63:0] a, b;
    op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_NOP, OP_UNUSED_TOP))
                                      : 4'($urandom_range(OP_SHL, OP_SET));
    cc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(COND_UNUSED_LOW, COND_UNUSED_TOP))
                                     : 4'($urandom_range(COND_A, COND_ALWAYS));
    ws = 2'($urandom_range(W8, W64));
    a  = rand_operand();
    b  = ($urandom_range(0, 1) == 0) ? rand_operand() : {$urandom, $urandom};
    // Keep most counts at or below 70, around and past each width; leave the upper bits random.
    if (op <= OP_RCR && $urandom_range(0, 3) != 0) b[6:0] = 7'($urandom_range(0, 70));
    push_req(op, cc, ws, a, b);
  endtask

  initial begin
    int total, k;
    rst_ni = 1'b0;

    // Directed: flag producers, then consumers that read them back.
    push_req(OP_ADC, COND_ALWAYS, W8,  64'h7f, 64'h01);          // signed overflow
    push_req(OP_ADC, COND_ALWAYS, W64, '1, 64'h1);               // 64-bit carry and zero
    push_req(OP_ADC, COND_ALWAYS, W16, 64'hffff, 64'h0);         // carry-in wraps to zero
    push_req(OP_JMP, COND_B, W64, 64'hdead_beef_0000_1234, '0);
    push_req(OP_SET, COND_E, W8, '1, '1);
    push_req(OP_SHL, COND_ALWAYS, W8, 64'h80, 64'h1);            // count one: CF and OF
    push_req(OP_SET, COND_O, W32, '0, '0);
    push_req(OP_SHR, COND_ALWAYS, W16, 64'h8000, 64'h1);
    push_req(OP_SAR, COND_ALWAYS, W32, 64'h8000_0000, 64'd31);
    push_req(OP_SHL, COND_ALWAYS, W8, 64'hff, 64'd8);            // count equal to width
    push_req(OP_SHL, COND_ALWAYS, W8, 64'hff, 64'd9);            // count past width
    push_req(OP_SHR, COND_ALWAYS, W16, 64'hffff, 64'd20);
    push_req(OP_SAR, COND_ALWAYS, W8, 64'h80, 64'd12);           // sign fill past width
    push_req(OP_SHL, COND_ALWAYS, W16, '1, 64'd32);              // masks to a zero count
    push_req(OP_ROL, COND_ALWAYS, W64, 64'h8000_0000_0000_0001, 64'd1);
    push_req(OP_ROR, COND_ALWAYS, W64, 64'h1, '1);               // masks to 63
    push_req(OP_ROL, COND_ALWAYS, W8, 64'h81, 64'd8);            // full-turn rotate
    push_req(OP_RCL, COND_ALWAYS, W8, 64'h81, 64'd9);            // wraps to zero modulo 9
    push_req(OP_RCR, COND_ALWAYS, W16, 64'h1234, 64'd17);        // wraps modulo 17
    push_req(OP_RCL, COND_ALWAYS, W32, 64'hc000_0001, 64'd31);
    push_req(OP_RCR, COND_ALWAYS, W64, 64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_ffc1);
    push_req(OP_JMP, COND_ALWAYS, W8, '1, '0);
    push_req(OP_JMP, COND_UNUSED_LOW, W8, '1, '0);               // unknown condition
    push_req(OP_SET, COND_UNUSED_TOP, W8, '0, '0);
    push_req(OP_NOP, COND_ALWAYS, W64, '1, '1);                  // unknown operations
    push_req(OP_UNUSED_TOP, COND_ALWAYS, W64, '1, '1);

    for (k = 0; k < RANDOM_ITEMS; k++) add_random_req();
    total = pending_req_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Drain: every request taken, every response seen, then a short quiet tail.
    while (req_accept_cnt != total) @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_rsp_q.size() != 0)
      report_mismatch("responses missing", 64'(expected_rsp_q.size()), 64'd0);
    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
